/* hdl/tet_pkg.sv */
//------------------------------------------------------------------------------
// tet_pkg: shared constants and helpers for the twist exponential transform
// Holds the arctangent table, angle constants and fixed point widths.
//------------------------------------------------------------------------------
`default_nettype none
package tet_pkg;

	localparam int SincosIterations = 16;
	localparam int AtanLen          = 24;

	localparam logic signed [34:0] HalfPiQ30 = 35'sd1686629713;
	localparam logic signed [34:0] PiQ30     = 35'sd3373259426;
	localparam logic signed [34:0] TwoPiQ30  = 35'sd6746518852;
	localparam logic signed [33:0] GainQ30   = 34'sd652032874;
	localparam logic signed [33:0] OneQ30    = 34'sd1073741824;

	// Arctangent of 2^-i in Q.30.
	function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
		logic signed [34:0] r;
		begin
			unique case (i)
				5'd0: r = 35'sd843314857;
				5'd1: r = 35'sd497837829;
				5'd2: r = 35'sd263043837;
				5'd3: r = 35'sd133525159;
				5'd4: r = 35'sd67021687;
				5'd5: r = 35'sd33543516;
				5'd6: r = 35'sd16775851;
				5'd7: r = 35'sd8388437;
				5'd8: r = 35'sd4194283;
				5'd9: r = 35'sd2097149;
				5'd10: r = 35'sd1048576;
				5'd11: r = 35'sd524288;
				5'd12: r = 35'sd262144;
				5'd13: r = 35'sd131072;
				5'd14: r = 35'sd65536;
				5'd15: r = 35'sd32768;
				5'd16: r = 35'sd16384;
				5'd17: r = 35'sd8192;
				5'd18: r = 35'sd4096;
				5'd19: r = 35'sd2048;
				5'd20: r = 35'sd1024;
				5'd21: r = 35'sd512;
				5'd22: r = 35'sd256;
				5'd23: r = 35'sd128;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// Saturate a 64 bit value to 32 bits signed.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		begin
			if (v > 64'sd2147483647) begin
				r = 32'sh7fffffff;
			end else if (v < -64'sd2147483648) begin
				r = 32'sh80000000;
			end else begin
				r = v[31:0];
			end
			return r;
		end
	endfunction

endpackage
`default_nettype wire

/* hdl/tet_cordic.sv */
//------------------------------------------------------------------------------
// tet_cordic: pipelined sine and cosine
// Range reduction stage followed by one register stage per CORDIC step.
//------------------------------------------------------------------------------
`default_nettype none
module tet_cordic #(
	parameter int ITER = tet_pkg::SincosIterations
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       en,
	input  wire logic signed [15:0]   angle,
	output logic signed [33:0]        sin_o,
	output logic signed [33:0]        cos_o
);

	localparam int N = (ITER < tet_pkg::AtanLen) ? ITER : tet_pkg::AtanLen;

	logic signed [34:0] z0;
	logic               neg0;
	logic signed [34:0] zr_s1;
	logic               neg_s1;

	always_comb begin
		logic signed [34:0] z;
		z    = 35'(angle) <<< 18;
		neg0 = 1'b0;
		for (int k = 0; k < 2; k++) begin
			if (z > tet_pkg::PiQ30) z = z - tet_pkg::TwoPiQ30;
			if (z <= -tet_pkg::PiQ30) z = z + tet_pkg::TwoPiQ30;
		end
		if (z > tet_pkg::HalfPiQ30) begin
			z = z - tet_pkg::PiQ30; neg0 = 1'b1;
		end else if (z < -tet_pkg::HalfPiQ30) begin
			z = z + tet_pkg::PiQ30; neg0 = 1'b1;
		end
		z0 = z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zr_s1  <= z0;
			neg_s1 <= neg0;
		end
	end

	logic signed [33:0] x_q [N+1];
	logic signed [33:0] y_q [N+1];
	logic signed [34:0] z_q [N+1];
	logic               n_q [N+1];

	assign x_q[0] = tet_pkg::GainQ30;
	assign y_q[0] = '0;
	assign z_q[0] = zr_s1;
	assign n_q[0] = neg_s1;

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - tet_pkg::atan_q30(5'(i));
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + tet_pkg::atan_q30(5'(i));
				end
				n_q[i+1] <= n_q[i];
			end
		end
	end

	assign cos_o = n_q[N] ? -x_q[N] : x_q[N];
	assign sin_o = n_q[N] ? -y_q[N] : y_q[N];

	logic unused;
	assign unused = ^{arst_n, z_q[N]};

endmodule
`default_nettype wire

/* hdl/tet_trans.sv */
//------------------------------------------------------------------------------
// tet_trans: pipelined twist vectors v = -W q and u = W v
// Two register stages; the result waits for the rotation terms downstream.
//------------------------------------------------------------------------------
`default_nettype none
module tet_trans (
	input  wire                       clk,
	input  wire                       en,
	input  wire logic signed [15:0]   wx,
	input  wire logic signed [15:0]   wy,
	input  wire logic signed [15:0]   wz,
	input  wire logic signed [31:0]   qx,
	input  wire logic signed [31:0]   qy,
	input  wire logic signed [31:0]   qz,
	output logic signed [31:0]        ux,
	output logic signed [31:0]        uy,
	output logic signed [31:0]        uz
);

	logic signed [31:0] v_s1 [3];
	logic signed [15:0] w_s1 [3];
	logic signed [63:0] a0, a1, a2, b0, b1, b2;

	// W q components: (wy qz - wz qy, wz qx - wx qz, wx qy - wy qx)
	always_comb begin
		a0 = 64'(wy) * 64'(qz) - 64'(wz) * 64'(qy);
		a1 = 64'(wz) * 64'(qx) - 64'(wx) * 64'(qz);
		a2 = 64'(wx) * 64'(qy) - 64'(wy) * 64'(qx);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1[0] <= tet_pkg::sat32((-a0 + 64'sd8192) >>> 14);
			v_s1[1] <= tet_pkg::sat32((-a1 + 64'sd8192) >>> 14);
			v_s1[2] <= tet_pkg::sat32((-a2 + 64'sd8192) >>> 14);
			w_s1    <= '{wx, wy, wz};
		end
	end

	always_comb begin
		b0 = 64'(w_s1[1]) * 64'(v_s1[2]) - 64'(w_s1[2]) * 64'(v_s1[1]);
		b1 = 64'(w_s1[2]) * 64'(v_s1[0]) - 64'(w_s1[0]) * 64'(v_s1[2]);
		b2 = 64'(w_s1[0]) * 64'(v_s1[1]) - 64'(w_s1[1]) * 64'(v_s1[0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux <= tet_pkg::sat32((b0 + 64'sd8192) >>> 14);
			uy <= tet_pkg::sat32((b1 + 64'sd8192) >>> 14);
			uz <= tet_pkg::sat32((b2 + 64'sd8192) >>> 14);
		end
	end

endmodule
`default_nettype wire

/* hdl/twist_exponential_transform_unit.sv */
//------------------------------------------------------------------------------
// twist_exponential_transform_unit: Rodrigues exponential of a twist on SE(3)
// Rotation matrix and translation from axis, point on axis and angle.
//------------------------------------------------------------------------------
// Usage:
// An input transfer carries the axis (Q1.14), a point on the axis (Q15.16)
// and an angle (Q3.12). One output transfer per input carries the nine
// rotation entries (Q1.14) and the translation (Q15.16), all saturated.
// The block is a single pipeline that advances as a whole whenever its last
// stage is empty or being drained, so while the receiver does not stall a new
// input transfer can be taken in every cycle: throughput is one item per cycle.
// A result passes through SINCOS_ITERATIONS + 4 register stages from the input
// transfer edge to output valid: the range reduction register loaded at the
// transfer edge, one stage per CORDIC step, then the rotation products, the
// rotation and (I - R) rounding, and the translation product stage. The CORDIC
// chain sets the depth.
// When the receiver stalls, the whole pipeline holds and in_ready falls
// while the output is occupied and not taken, so nothing is lost or repeated.
// Reset clears only the valid bits; the pipeline then reads empty.
//------------------------------------------------------------------------------
`default_nettype none
module twist_exponential_transform_unit #(
	parameter int SINCOS_ITERATIONS = tet_pkg::SincosIterations
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire logic signed [15:0]   axis_x,
	input  wire logic signed [15:0]   axis_y,
	input  wire logic signed [15:0]   axis_z,
	input  wire logic signed [31:0]   point_x,
	input  wire logic signed [31:0]   point_y,
	input  wire logic signed [31:0]   point_z,
	input  wire logic signed [15:0]   angle,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic signed [15:0]        rot_00,
	output logic signed [15:0]        rot_01,
	output logic signed [15:0]        rot_02,
	output logic signed [15:0]        rot_10,
	output logic signed [15:0]        rot_11,
	output logic signed [15:0]        rot_12,
	output logic signed [15:0]        rot_20,
	output logic signed [15:0]        rot_21,
	output logic signed [15:0]        rot_22,
	output logic signed [31:0]        trans_x,
	output logic signed [31:0]        trans_y,
	output logic signed [31:0]        trans_z
);

	localparam int N   = (SINCOS_ITERATIONS < tet_pkg::AtanLen) ?
		SINCOS_ITERATIONS : tet_pkg::AtanLen;
	localparam int LAT = N + 4;

	// The pipeline advances whenever the output stage is free or drains.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[LAT-1];

	logic signed [33:0] s_w, c_w;
	tet_cordic #(.ITER(N)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .angle(angle),
		.sin_o(s_w), .cos_o(c_w)
	);

	// The axis and point travel alongside the CORDIC chain.
	logic signed [15:0] wd_q [N+1][3];
	logic signed [31:0] qd_q [N+1][3];
	always_ff @(posedge clk) begin
		if (en) begin
			wd_q[0] <= '{axis_x, axis_y, axis_z};
			qd_q[0] <= '{point_x, point_y, point_z};
			for (int i = 0; i < N; i++) begin
				wd_q[i+1] <= wd_q[i];
				qd_q[i+1] <= qd_q[i];
			end
		end
	end

	// The skew matrix and W*W are formed during the last CORDIC step, from
	// the axis one stage behind, so that stage A holds a single product.
	logic signed [15:0] w0, w1, w2;
	assign w0 = wd_q[N-1][0];
	assign w1 = wd_q[N-1][1];
	assign w2 = wd_q[N-1][2];

	logic signed [16:0] sk [3][3];
	logic signed [33:0] sq [3][3];
	always_comb begin
		sk[0][0] = '0;        sk[0][1] = -17'(w2); sk[0][2] = 17'(w1);
		sk[1][0] = 17'(w2);   sk[1][1] = '0;       sk[1][2] = -17'(w0);
		sk[2][0] = -17'(w1);  sk[2][1] = 17'(w0);  sk[2][2] = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				sq[i][j] = 34'(sk[i][0]) * 34'(sk[0][j]) + 34'(sk[i][1]) * 34'(sk[1][j])
					+ 34'(sk[i][2]) * 34'(sk[2][j]);
			end
		end
	end

	logic signed [16:0] sk_q [3][3];
	logic signed [33:0] sq_q [3][3];
	always_ff @(posedge clk) begin
		if (en) begin
			sk_q <= sk;
			sq_q <= sq;
		end
	end

	// Stage A: the sin and (1 - cos) products.
	logic signed [34:0] c1;
	assign c1 = 35'(tet_pkg::OneQ30) - 35'(c_w);

	logic signed [63:0] sw_a [3][3];
	logic signed [63:0] cs_a [3][3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					sw_a[i][j] <= 64'(s_w) * 64'(sk_q[i][j]);
					cs_a[i][j] <= 64'(c1) * 64'(sq_q[i][j]);
				end
			end
		end
	end

	// Stage B: P, rotation entries and the saturated (I - R).
	logic signed [63:0] p_b [3][3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				p_b[i][j] = sw_a[i][j] + ((cs_a[i][j] + 64'sd8192) >>> 14);
			end
		end
	end

	logic signed [15:0] rot_b [3][3];
	logic signed [30:0] m_b   [3][3];
	always_ff @(posedge clk) begin
		logic signed [63:0] r, m;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					r = ((i == j ? 64'sd17592186044416 : 64'sd0) + p_b[i][j]
						+ 64'sd536870912) >>> 30;
					rot_b[i][j] <= (r > 64'sd32767) ? 16'sh7fff :
						(r < -64'sd32768) ? 16'sh8000 : r[15:0];
					m = (-p_b[i][j] + 64'sd32768) >>> 16;
					m_b[i][j] <= (m > 64'sd1073741823) ? 31'sh3fffffff :
						(m < -64'sd1073741824) ? 31'sh40000000 : m[30:0];
				end
			end
		end
	end

	// Twist vectors run in parallel with stages A and B; u lands in the same
	// cycle as (I - R).
	logic signed [31:0] ux, uy, uz;
	tet_trans u_trans (
		.clk(clk), .en(en),
		.wx(wd_q[N][0]), .wy(wd_q[N][1]), .wz(wd_q[N][2]),
		.qx(qd_q[N][0]), .qy(qd_q[N][1]), .qz(qd_q[N][2]),
		.ux(ux), .uy(uy), .uz(uz)
	);

	// Stage C: translation (I - R) u, and the output register.
	logic signed [31:0] u_c [3];
	assign u_c = '{ux, uy, uz};
	always_ff @(posedge clk) begin
		logic signed [63:0] acc [3];
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				acc[i] = 64'(m_b[i][0]) * 64'(u_c[0]) + 64'(m_b[i][1]) * 64'(u_c[1])
					+ 64'(m_b[i][2]) * 64'(u_c[2]);
			end
			trans_x <= tet_pkg::sat32((acc[0] + 64'sd134217728) >>> 28);
			trans_y <= tet_pkg::sat32((acc[1] + 64'sd134217728) >>> 28);
			trans_z <= tet_pkg::sat32((acc[2] + 64'sd134217728) >>> 28);
			rot_00 <= rot_b[0][0]; rot_01 <= rot_b[0][1]; rot_02 <= rot_b[0][2];
			rot_10 <= rot_b[1][0]; rot_11 <= rot_b[1][1]; rot_12 <= rot_b[1][2];
			rot_20 <= rot_b[2][0]; rot_21 <= rot_b[2][1]; rot_22 <= rot_b[2][2];
		end
	end

`ifndef SYNTHESIS
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("in_ready low with empty output");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && !vld_q[LAT-2]) |=> !out_valid) else $error("result invented");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
//------------------------------------------------------------------------------
// tb: regression for the twist exponential transform unit
// Drives axis, point and angle transfers with random idling on both sides,
// predicts the rotation and translation with a bit-true fixed point model and
// compares every output transfer field by field in order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;

	localparam int CordicSteps = tet_pkg::SincosIterations;
	localparam int IdleMax     = 18;
	localparam int StallLimit  = 4000;
	localparam int DrainCycles = CordicSteps + 16;

	typedef struct {
		logic signed [15:0] ax, ay, az;
		logic signed [31:0] px, py, pz;
		logic signed [15:0] ang;
	} twist_t;

	typedef struct {
		logic signed [15:0] rot [9];
		logic signed [31:0] tr [3];
	} pose_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] axis_x, axis_y, axis_z, angle;
	logic signed [31:0] point_x, point_y, point_z;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
	logic signed [15:0] rot_20, rot_21, rot_22;
	logic signed [31:0] trans_x, trans_y, trans_z;

	pose_t expected_poses [$];
	int mismatch_count;
	int stall_cycles;
	bit timed_out;

	twist_exponential_transform_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.angle(angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.rot_00(rot_00), .rot_01(rot_01), .rot_02(rot_02),
		.rot_10(rot_10), .rot_11(rot_11), .rot_12(rot_12),
		.rot_20(rot_20), .rot_21(rot_21), .rot_22(rot_22),
		.trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Arithmetic shift right is a floor divide on signed longint.
	function automatic longint round_shift(longint v, int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint arctan_step(int i);
		longint atan_tbl [24] = '{843314857, 497837829, 263043837, 133525159,
			67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
			524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
			512, 256, 128};
		return atan_tbl[i];
	endfunction

	// Expected pose for one twist.
	function automatic pose_t exp_twist(twist_t t);
		pose_t p;
		longint half_pi, pi_q, two_pi, z, x, y, nx, s, c, c1, sq, part, acc;
		longint lo32, hi32;
		longint w [3];
		longint q [3];
		longint sk [3][3];
		longint m [3][3];
		longint v [3];
		longint u [3];
		bit flip;
		half_pi = 1686629713;
		pi_q = 2 * half_pi;
		two_pi = 4 * half_pi;
		lo32 = -(longint'(1) << 31);
		hi32 = (longint'(1) << 31) - 1;
		w = '{t.ax, t.ay, t.az};
		q = '{t.px, t.py, t.pz};
		z = longint'(t.ang) * (longint'(1) << 18);
		for (int k = 0; k < 2; k++) begin
			if (z > pi_q) z -= two_pi;
			if (z <= -pi_q) z += two_pi;
		end
		flip = 1'b0;
		if (z > half_pi) begin
			z -= pi_q;
			flip = 1'b1;
		end else if (z < -half_pi) begin
			z += pi_q;
			flip = 1'b1;
		end
		x = 652032874;
		y = 0;
		for (int i = 0; i < CordicSteps && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_step(i);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_step(i);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
		c1 = (longint'(1) << 30) - c;
		sk = '{'{0, -w[2], w[1]}, '{w[2], 0, -w[0]}, '{-w[1], w[0], 0}};
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				sq = 0;
				for (int k = 0; k < 3; k++) sq += sk[i][k] * sk[k][j];
				part = s * sk[i][j] + round_shift(c1 * sq, 14);
				acc = (i == j ? (longint'(1) << 44) : 0) + part;
				p.rot[i * 3 + j] = 16'(clamp(round_shift(acc, 30), -32768, 32767));
				m[i][j] = clamp(round_shift(-part, 16), -(longint'(1) << 30),
					(longint'(1) << 30) - 1);
			end
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) acc += sk[i][j] * q[j];
			v[i] = clamp(round_shift(-acc, 14), lo32, hi32);
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) acc += sk[i][j] * v[j];
			u[i] = clamp(round_shift(acc, 14), lo32, hi32);
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) acc += m[i][j] * u[j];
			p.tr[i] = 32'(clamp(round_shift(acc, 28), lo32, hi32));
		end
		return p;
	endfunction

	function automatic logic signed [15:0] pick_axis();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_point();
		case ($urandom_range(0, 3))
			0: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	// A rotation about one principal direction, as the block is normally used.
	function automatic twist_t unit_twist();
		twist_t t;
		t.ax = '0;
		t.ay = '0;
		t.az = '0;
		case ($urandom_range(0, 2))
			0: t.ax = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
			1: t.ay = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
			default: t.az = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
		endcase
		t.px = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
		t.py = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
		t.pz = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
		t.ang = 16'($urandom);
		return t;
	endfunction

	function automatic twist_t any_twist();
		twist_t t;
		t.ax = pick_axis();
		t.ay = pick_axis();
		t.az = pick_axis();
		t.px = pick_point();
		t.py = pick_point();
		t.pz = pick_point();
		t.ang = 16'($urandom);
		return t;
	endfunction

	// One input transfer after a random gap; the expectation is queued when
	// the transfer happens. Valid stays high after the transfer, so a
	// following item with no gap goes out back to back; the next gap or
	// wait_empty drops it.
	task automatic send_twist(twist_t t, bit no_gap = 1'b0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, IdleMax);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		axis_x <= t.ax;
		axis_y <= t.ay;
		axis_z <= t.az;
		point_x <= t.px;
		point_y <= t.py;
		point_z <= t.pz;
		angle <= t.ang;
		do @(posedge clk); while (!in_ready);
		expected_poses.push_back(exp_twist(t));
	endtask

	task automatic wait_empty();
		in_valid <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
	endtask

	task automatic test_axis_extremes();
		twist_t t;
		logic signed [15:0] corner [3] = '{16'sd16384, -16'sd16384, 16'sd0};
		for (int i = 0; i < 3; i++) begin
			t = '{corner[i], corner[(i + 1) % 3], corner[(i + 2) % 3],
				32'sh7fffffff, 32'sh80000000, 32'sd65536, 16'sd6434};
			send_twist(t);
		end
		// Non-unit axes: field extremes saturate the outputs, then a zero twist.
		t = '{-16'sh8000, 16'sh7fff, -16'sh8000, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, -16'sh8000};
		send_twist(t);
		t = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 16'sh7fff};
		send_twist(t);
		t = '{16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0};
		send_twist(t);
	endtask

	// Angles on and around the wrap and quadrant boundaries (pi is about
	// 12868 and pi/2 about 6434 in Q3.12).
	task automatic test_angle_wrap();
		logic signed [15:0] angles [12] = '{16'sd0, 16'sd6433, 16'sd6434,
			16'sd6435, -16'sd6434, -16'sd6435, 16'sd12867, 16'sd12868,
			-16'sd12868, 16'sd25736, 16'sh7fff, -16'sh8000};
		twist_t t;
		foreach (angles[i]) begin
			t = unit_twist();
			t.ang = angles[i];
			send_twist(t, i[0]);
		end
	endtask

	// Unit-axis rotations in three draws of four; the rest and bursts are random.
	task automatic test_random_twists(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 3) != 0) send_twist(unit_twist());
			else send_twist(any_twist());
			// A burst now and then keeps the pipeline full.
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(2, 30)) send_twist(any_twist(), 1'b1);
			end
		end
	endtask

	// Let the pipeline drain completely before sending on.
	task automatic test_drain_pause();
		send_twist(any_twist());
		wait_empty();
		repeat (DrainCycles) @(posedge clk);
		repeat (40) send_twist(unit_twist(), 1'b1);
	endtask

	// The receiver takes each output transfer after its own random stall,
	// with occasional long stretches of no stall at all.
	initial begin
		int stall;
		int run;
		out_ready = 1'b0;
		run = 0;
		@(posedge arst_n);
		forever begin
			if (run > 0) begin
				run--;
				stall = 0;
			end else begin
				stall = $urandom_range(0, IdleMax);
				if ($urandom_range(0, 19) == 0) run = $urandom_range(20, 80);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Each output transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		pose_t want;
		logic signed [15:0] got_rot [9];
		logic signed [31:0] got_tr [3];
		bit bad;
		if (arst_n && out_valid && out_ready) begin
			got_rot = '{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
				rot_20, rot_21, rot_22};
			got_tr = '{trans_x, trans_y, trans_z};
			if (expected_poses.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: output transfer with nothing expected", $realtime);
			end else begin
				want = expected_poses.pop_front();
				bad = 1'b0;
				for (int i = 0; i < 9; i++) bad |= got_rot[i] !== want.rot[i];
				for (int i = 0; i < 3; i++) bad |= got_tr[i] !== want.tr[i];
				if (bad) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: rot exp %p got %p", $realtime, want.rot, got_rot);
						$display("%0t: trans exp %p got %p", $realtime, want.tr, got_tr);
					end
				end
			end
		end
	end

	// Watchdog: counts cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
	end

	initial begin
		mismatch_count = 0;
		stall_cycles = 0;
		timed_out = 1'b0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		axis_x <= '0;
		axis_y <= '0;
		axis_z <= '0;
		point_x <= '0;
		point_y <= '0;
		point_z <= '0;
		angle <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			begin
				test_axis_extremes();
				test_angle_wrap();
				test_drain_pause();
				test_random_twists(700);
				wait_empty();
				repeat (DrainCycles) @(posedge clk);
			end
			begin
				wait (stall_cycles >= StallLimit);
				timed_out = 1'b1;
			end
		join_any
		disable fork;
		if (timed_out || expected_poses.size() != 0 || mismatch_count != 0) begin
			$display("[FAIL] regression broken");
		end else begin
			$display("[ OK ] regression clean");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
hdl/tet_pkg.sv
hdl/tet_cordic.sv
hdl/tet_trans.sv
hdl/twist_exponential_transform_unit.sv
tb/tb.sv
